// ===== design/uartp_pkg.sv =====
// ----------------------------------------------------------------------------
// uartp_pkg
// shared types, phase codes, register indexes and helpers for the uart
// transceiver with parity
// ----------------------------------------------------------------------------
package uartp_pkg;

    localparam int DATA_BITS = 8;
    localparam int PHASE_W   = 4;
    localparam int PERIOD_W  = 16;
    localparam int RX_TIMER_W = 17;

    // transmit phases
    localparam logic [PHASE_W-1:0] TX_IDLE  = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] TX_START = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] TX_PAR   = PHASE_W'(DATA_BITS + 2);
    localparam logic [PHASE_W-1:0] TX_STOP  = PHASE_W'(DATA_BITS + 3);

    // receive phases
    localparam logic [PHASE_W-1:0] RX_IDLE  = PHASE_W'(0);
    localparam logic [PHASE_W-1:0] RX_FIRST = PHASE_W'(1);
    localparam logic [PHASE_W-1:0] RX_PAR   = PHASE_W'(DATA_BITS + 1);
    localparam logic [PHASE_W-1:0] RX_STOP  = PHASE_W'(DATA_BITS + 2);

    // parity modes
    localparam logic [1:0] PARITY_NONE = 2'd0;
    localparam logic [1:0] PARITY_EVEN = 2'd1;
    localparam logic [1:0] PARITY_ODD  = 2'd2;

    // receive status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FRAME  = 2'd1;
    localparam logic [1:0] STATUS_PARITY = 2'd2;

    // register indexes
    localparam logic REG_BIT_PERIOD = 1'b0;
    localparam logic REG_PARITY_SEL = 1'b1;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = PERIOD_W'(7500);

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period;
        logic [1:0]          parity_sel;
    } cfg_t;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_out_t;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
        logic [1:0] status;
    } rx_out_t;

    function automatic logic [PERIOD_W-1:0] period_ticks(input logic [PERIOD_W-1:0] bp);
        period_ticks = (bp == '0) ? PERIOD_W'(1) : bp;
    endfunction

    function automatic logic parity_on(input logic [1:0] mode);
        parity_on = (mode == PARITY_EVEN) || (mode == PARITY_ODD);
    endfunction

    function automatic logic odd_flag(input logic [1:0] mode);
        odd_flag = (mode == PARITY_ODD);
    endfunction

    function automatic logic byte_xor(input logic [7:0] b);
        logic x;
        x = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < DATA_BITS)
            begin
                x = x ^ b[i];
            end
        end
        byte_xor = x;
    endfunction

endpackage

// ===== design/uartp_tx.sv =====
// ----------------------------------------------------------------------------
// uartp_tx
// transmitter: frame state, bit timer and shift register, advanced once per
// accepted request; line level and busy for the current tick
// ----------------------------------------------------------------------------
module uartp_tx (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  uartp_pkg::cfg_t              cfg,
    input  logic                         send_request,
    input  logic [7:0]                   send_byte,
    output uartp_pkg::tx_out_t           result
);

    logic [uartp_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [7:0]                     shift_reg, shift_next;
    logic [uartp_pkg::PERIOD_W-1:0] timer_reg, timer_next;
    logic                           par_reg, par_next;

    logic [uartp_pkg::PERIOD_W-1:0] period;
    logic [uartp_pkg::PERIOD_W:0]   timer_inc;
    logic [uartp_pkg::PHASE_W-1:0]  advance;

    assign period = uartp_pkg::period_ticks(cfg.bit_period);

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        timer_next  = timer_reg;
        par_next    = par_reg;
        result.line = 1'b1;
        result.busy = 1'b0;
        timer_inc   = '0;
        advance     = '0;

        // start of frame
        if (phase_reg == uartp_pkg::TX_IDLE && send_request)
        begin
            shift_next = send_byte;
            par_next   = uartp_pkg::byte_xor(send_byte) ^ uartp_pkg::odd_flag(cfg.parity_sel);
            phase_next = uartp_pkg::TX_START;
            timer_next = '0;
        end

        if (phase_next != uartp_pkg::TX_IDLE)
        begin
            result.busy = 1'b1;
            if (phase_next == uartp_pkg::TX_START)
            begin
                result.line = 1'b0;
            end
            else if (phase_next < uartp_pkg::TX_PAR)
            begin
                result.line = shift_next[0];
            end
            else if (phase_next == uartp_pkg::TX_PAR)
            begin
                result.line = par_next;
            end
            else
            begin
                result.line = 1'b1;
            end

            timer_inc = {1'b0, timer_next} + 1'b1;
            if (timer_inc >= {1'b0, period})
            begin
                timer_next = '0;
                if (phase_next > uartp_pkg::TX_START && phase_next < uartp_pkg::TX_PAR)
                begin
                    shift_next = shift_next >> 1;
                end
                advance = phase_next + 1'b1;
                if (advance == uartp_pkg::TX_PAR && !uartp_pkg::parity_on(cfg.parity_sel))
                begin
                    advance = uartp_pkg::TX_STOP;
                end
                if (phase_next >= uartp_pkg::TX_STOP)
                begin
                    advance = uartp_pkg::TX_IDLE;
                end
                phase_next = advance;
            end
            else
            begin
                timer_next = timer_inc[uartp_pkg::PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uartp_pkg::TX_IDLE;
            shift_reg <= '0;
            timer_reg <= '0;
            par_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
            par_reg   <= par_next;
        end
    end

endmodule

// ===== design/uartp_rx.sv =====
// ----------------------------------------------------------------------------
// uartp_rx
// receiver: start detect, mid-bit sample timer, data and parity capture and
// stop check, advanced once per accepted request
// ----------------------------------------------------------------------------
module uartp_rx (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  uartp_pkg::cfg_t      cfg,
    input  logic                 rx_line,
    output uartp_pkg::rx_out_t   result
);

    logic [uartp_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [uartp_pkg::RX_TIMER_W-1:0] timer_reg, timer_next;
    logic                             seen_reg, seen_next;

    logic [uartp_pkg::PERIOD_W-1:0]   period;
    logic [uartp_pkg::RX_TIMER_W:0]   period_x3;
    logic [uartp_pkg::PHASE_W-1:0]    idx;

    assign period    = uartp_pkg::period_ticks(cfg.bit_period);
    assign period_x3 = {2'b00, period} + {1'b0, period, 1'b0};
    assign idx       = phase_reg - uartp_pkg::RX_FIRST;

    always_comb
    begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        timer_next    = timer_reg;
        seen_next     = seen_reg;
        result.done   = 1'b0;
        result.data   = '0;
        result.status = uartp_pkg::STATUS_OK;

        if (phase_reg == uartp_pkg::RX_IDLE)
        begin
            if (!rx_line)
            begin
                phase_next = uartp_pkg::RX_FIRST;
                timer_next = period_x3[uartp_pkg::RX_TIMER_W:1];
                shift_next = '0;
                seen_next  = 1'b0;
            end
        end
        else if (timer_reg > uartp_pkg::RX_TIMER_W'(1))
        begin
            timer_next = timer_reg - 1'b1;
        end
        else
        begin
            timer_next = {1'b0, period};
            if (phase_reg < uartp_pkg::RX_PAR)
            begin
                if (idx < uartp_pkg::PHASE_W'(8))
                begin
                    shift_next[idx[2:0]] = shift_reg[idx[2:0]] | rx_line;
                end
                seen_next  = seen_reg ^ rx_line;
                phase_next = phase_reg + 1'b1;
                if (phase_next == uartp_pkg::RX_PAR && !uartp_pkg::parity_on(cfg.parity_sel))
                begin
                    seen_next  = 1'b0;
                    phase_next = uartp_pkg::RX_STOP;
                end
            end
            else if (phase_reg == uartp_pkg::RX_PAR)
            begin
                // turns into the mismatch flag
                seen_next  = seen_reg ^ rx_line ^ uartp_pkg::odd_flag(cfg.parity_sel);
                phase_next = uartp_pkg::RX_STOP;
            end
            else
            begin
                result.done = 1'b1;
                result.data = shift_reg;
                if (!rx_line)
                begin
                    result.status = uartp_pkg::STATUS_FRAME;
                end
                else if (seen_reg)
                begin
                    result.status = uartp_pkg::STATUS_PARITY;
                end
                phase_next = uartp_pkg::RX_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uartp_pkg::RX_IDLE;
            shift_reg <= '0;
            timer_reg <= '0;
            seen_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== design/uart_transceiver_parity.sv =====
// ----------------------------------------------------------------------------
// uart_transceiver_parity
// uart transmitter and receiver with optional even or odd parity, one
// request per clock tick of the serial line, apb register port
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    rx_line, send_request, send_byte
//   out       output     out_valid/out_ready  tx_line, tx_busy, rx_done,
//                                             rx_byte, rx_status
//   apb       input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// one request per cycle; each request leaves its result in the output
// register in the cycle after, set by the tx and rx state update; in_ready
// is high when the output register is empty or being drained, so a stalled
// output holds one result and blocks further requests; reset clears both
// state machines and the output valid flag and resets the config registers
// ----------------------------------------------------------------------------
module uart_transceiver_parity (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        rx_line,
    input  logic        send_request,
    input  logic [7:0]  send_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        tx_line,
    output logic        tx_busy,
    output logic        rx_done,
    output logic [7:0]  rx_byte,
    output logic [1:0]  rx_status,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    uartp_pkg::cfg_t      cfg_reg;
    uartp_pkg::tx_out_t   tx_res;
    uartp_pkg::rx_out_t   rx_res;
    logic                 step;
    logic                 out_valid_reg;
    uartp_pkg::tx_out_t   tx_res_reg;
    uartp_pkg::rx_out_t   rx_res_reg;

    assign pready   = 1'b1;
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period <= uartp_pkg::BIT_PERIOD_RESET;
            cfg_reg.parity_sel <= uartp_pkg::PARITY_NONE;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                uartp_pkg::REG_BIT_PERIOD: cfg_reg.bit_period <= pwdata[15:0];
                uartp_pkg::REG_PARITY_SEL: cfg_reg.parity_sel <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            uartp_pkg::REG_BIT_PERIOD: prdata = {16'b0, cfg_reg.bit_period};
            uartp_pkg::REG_PARITY_SEL: prdata = {30'b0, cfg_reg.parity_sel};
            default:                   prdata = '0;
        endcase
    end

    uartp_tx u_tx (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .cfg          (cfg_reg),
        .send_request (send_request),
        .send_byte    (send_byte),
        .result       (tx_res)
    );

    uartp_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cfg     (cfg_reg),
        .rx_line (rx_line),
        .result  (rx_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tx_res_reg <= tx_res;
            rx_res_reg <= rx_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_line   = tx_res_reg.line;
    assign tx_busy   = tx_res_reg.busy;
    assign rx_done   = rx_res_reg.done;
    assign rx_byte   = rx_res_reg.data;
    assign rx_status = rx_res_reg.status;

endmodule

// ===== design/uartp_checker.sv =====
// ----------------------------------------------------------------------------
// uartp_checker
// port-level checks for the uart transceiver, bound to the top level
// ----------------------------------------------------------------------------
module uartp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        tx_line,
    input logic        tx_busy,
    input logic        rx_done,
    input logic [7:0]  rx_byte,
    input logic [1:0]  rx_status
);

    // an accepted request always shows up as a result next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request produced no result");

    // an empty output register never blocks input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // idle transmitter keeps the line high
    a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_busy |-> tx_line)
        else $error("tx line low while not busy");

    // receive fields are clear unless a frame completes, status in range
    a_rx_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rx_status == uartp_pkg::STATUS_OK
            || rx_status == uartp_pkg::STATUS_FRAME
            || rx_status == uartp_pkg::STATUS_PARITY)
            && (rx_done || (rx_byte == 8'd0 && rx_status == uartp_pkg::STATUS_OK)))
        else $error("bad receive fields");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_line) && $stable(tx_busy)
            && $stable(rx_done) && $stable(rx_byte) && $stable(rx_status))
        else $error("stalled result changed");

endmodule

bind uart_transceiver_parity uartp_checker u_uartp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_line   (tx_line),
    .tx_busy   (tx_busy),
    .rx_done   (rx_done),
    .rx_byte   (rx_byte),
    .rx_status (rx_status)
);
